// File: design/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros for the checker file of the node and weight unit.
// Each macro expects signals named clk and rst in the scope where it is used.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define GLNW_ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define GLNW_ASSERT_NXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: design/glnw_pkg.sv
// ----------------------------------------------------------------------------
// glnw_pkg
// Shared constants, types and the micro-program of the Gauss-Legendre node
// and weight unit.
// ----------------------------------------------------------------------------
package glnw_pkg;

  // Sizing of the unit.
  localparam int MAX_DEGREE       = 64;
  localparam int MAX_NEWTON_STEPS = 10;
  localparam int FRAC_BITS        = 45;
  localparam int COS_TERMS        = 12;

  localparam int DEG_W = 7;
  localparam int IDX_W = 6;
  localparam int N_W   = $clog2(MAX_DEGREE + 1);
  localparam int L_W   = (N_W > 4) ? N_W : 4;
  localparam int J_W   = $clog2(MAX_NEWTON_STEPS + 1);
  localparam int PC_W  = 6;
  localparam int IMM_W = 16;

  // Arithmetic widths: magnitudes never exceed the saturation limit.
  localparam int MAG_W      = 62;
  localparam int HALF_W     = MAG_W / 2;
  localparam int ACC_W      = 2 * MAG_W;
  localparam int DIV_CYCLES = 32;

  localparam logic [63:0] LIM    = 64'h3FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0] PI_Q61 = 64'h6487_ED51_10B4_611A;
  localparam logic [63:0] ONE_F  = 64'd1 << FRAC_BITS;
  localparam logic [63:0] PI_F   = (PI_Q61 + (64'd1 << (60 - FRAC_BITS))) >> (61 - FRAC_BITS);
  localparam logic [63:0] TOL    = (64'd1 << FRAC_BITS) / 64'd10000000000;

  // Datapath operations.
  localparam logic [2:0] OP_ADD  = 3'd0;
  localparam logic [2:0] OP_SUB  = 3'd1;
  localparam logic [2:0] OP_MUL  = 3'd2;
  localparam logic [2:0] OP_MULI = 3'd3;
  localparam logic [2:0] OP_DIV  = 3'd4;
  localparam logic [2:0] OP_DIVI = 3'd5;

  // Operand sources; the register codes double as destinations.
  localparam logic [3:0] SRC_X    = 4'd0;
  localparam logic [3:0] SRC_XO   = 4'd1;
  localparam logic [3:0] SRC_P    = 4'd2;
  localparam logic [3:0] SRC_P1   = 4'd3;
  localparam logic [3:0] SRC_P2   = 4'd4;
  localparam logic [3:0] SRC_DP   = 4'd5;
  localparam logic [3:0] SRC_C    = 4'd6;
  localparam logic [3:0] SRC_TERM = 4'd7;
  localparam logic [3:0] SRC_T2   = 4'd8;
  localparam logic [3:0] SRC_A    = 4'd9;
  localparam logic [3:0] SRC_B    = 4'd10;
  localparam logic [3:0] SRC_W    = 4'd11;
  localparam logic [3:0] SRC_ZERO = 4'd12;
  localparam logic [3:0] SRC_ONE  = 4'd13;
  localparam logic [3:0] SRC_PI   = 4'd14;
  localparam logic [3:0] SRC_IMM  = 4'd15;

  // Immediate selections made by the controller.
  localparam logic [3:0] IM_NONE  = 4'd0;
  localparam logic [3:0] IM_4I1   = 4'd1;
  localparam logic [3:0] IM_4N2   = 4'd2;
  localparam logic [3:0] IM_N     = 4'd3;
  localparam logic [3:0] IM_NM1   = 4'd4;
  localparam logic [3:0] IM_COSK  = 4'd5;
  localparam logic [3:0] IM_2L1   = 4'd6;
  localparam logic [3:0] IM_LM1   = 4'd7;
  localparam logic [3:0] IM_L     = 4'd8;
  localparam logic [3:0] IM_TWO   = 4'd9;
  localparam logic [3:0] IM_EIGHT = 4'd10;

  // Sequencing after a micro-operation completes.
  localparam logic [2:0] FL_NONE        = 3'd0;
  localparam logic [2:0] FL_COS_INIT    = 3'd1;
  localparam logic [2:0] FL_COS_LOOP    = 3'd2;
  localparam logic [2:0] FL_NEWTON_INIT = 3'd3;
  localparam logic [2:0] FL_REC_ENTRY   = 3'd4;
  localparam logic [2:0] FL_REC_LOOP    = 3'd5;
  localparam logic [2:0] FL_NEWTON_LOOP = 3'd6;
  localparam logic [2:0] FL_END         = 3'd7;

  // Jump targets in the micro-program.
  localparam logic [PC_W-1:0] PC_COS_BODY   = 6'd5;
  localparam logic [PC_W-1:0] PC_NEWTON_TOP = 6'd17;
  localparam logic [PC_W-1:0] PC_REC_BODY   = 6'd19;
  localparam logic [PC_W-1:0] PC_REC_END    = 6'd26;

  typedef struct packed {
    logic [2:0] op;
    logic [3:0] dst;
    logic [3:0] sa;
    logic [3:0] sb;
    logic [3:0] imm;
    logic [2:0] flow;
  } uop_t;

  typedef struct packed {
    logic             start;
    logic [2:0]       op;
    logic [3:0]       dst;
    logic [3:0]       sa;
    logic [3:0]       sb;
    logic [IMM_W-1:0] imm;
    logic             mirror;
  } dp_cmd_t;

  typedef struct packed {
    logic done;
    logic below_tol;
  } dp_stat_t;

  function automatic uop_t mk(input logic [2:0] op, input logic [3:0] dst,
                              input logic [3:0] sa, input logic [3:0] sb,
                              input logic [3:0] imm, input logic [2:0] flow);
    uop_t u;
    u.op   = op;
    u.dst  = dst;
    u.sa   = sa;
    u.sb   = sb;
    u.imm  = imm;
    u.flow = flow;
    return u;
  endfunction

  // Divisor of the cosine series term l: (2l-1)(2l).
  function automatic logic [IMM_W-1:0] cos_div(input logic [3:0] l);
    logic [4:0] t;
    t = {l, 1'b0};
    return IMM_W'(10'(t - 5'd1) * 10'(t));
  endfunction

  // Micro-program: initial guess, Newton steps, weight.
  function automatic uop_t uop_at(input logic [PC_W-1:0] pc);
    uop_t u;
    unique case (pc)
      // Angle and cosine series.
      6'd0:  u = mk(OP_MULI, SRC_A, SRC_PI, SRC_IMM, IM_4I1, FL_NONE);
      6'd1:  u = mk(OP_DIVI, SRC_B, SRC_A, SRC_IMM, IM_4N2, FL_NONE);
      6'd2:  u = mk(OP_MUL, SRC_T2, SRC_B, SRC_B, IM_NONE, FL_NONE);
      6'd3:  u = mk(OP_ADD, SRC_C, SRC_ONE, SRC_ZERO, IM_NONE, FL_NONE);
      6'd4:  u = mk(OP_ADD, SRC_TERM, SRC_ONE, SRC_ZERO, IM_NONE, FL_COS_INIT);
      6'd5:  u = mk(OP_MUL, SRC_A, SRC_TERM, SRC_T2, IM_NONE, FL_NONE);
      6'd6:  u = mk(OP_DIVI, SRC_A, SRC_A, SRC_IMM, IM_COSK, FL_NONE);
      6'd7:  u = mk(OP_SUB, SRC_TERM, SRC_ZERO, SRC_A, IM_NONE, FL_NONE);
      6'd8:  u = mk(OP_ADD, SRC_C, SRC_C, SRC_TERM, IM_NONE, FL_COS_LOOP);
      // Scale factor 1 - (n-1)/(8n^3) and the starting point.
      6'd9:  u = mk(OP_ADD, SRC_B, SRC_IMM, SRC_ZERO, IM_N, FL_NONE);
      6'd10: u = mk(OP_MULI, SRC_B, SRC_B, SRC_IMM, IM_N, FL_NONE);
      6'd11: u = mk(OP_MULI, SRC_B, SRC_B, SRC_IMM, IM_N, FL_NONE);
      6'd12: u = mk(OP_MULI, SRC_B, SRC_B, SRC_IMM, IM_EIGHT, FL_NONE);
      6'd13: u = mk(OP_DIV, SRC_A, SRC_IMM, SRC_B, IM_NM1, FL_NONE);
      6'd14: u = mk(OP_SUB, SRC_A, SRC_ONE, SRC_A, IM_NONE, FL_NONE);
      6'd15: u = mk(OP_MUL, SRC_A, SRC_A, SRC_C, IM_NONE, FL_NONE);
      6'd16: u = mk(OP_SUB, SRC_X, SRC_ZERO, SRC_A, IM_NONE, FL_NEWTON_INIT);
      // Newton step: Legendre recurrence.
      6'd17: u = mk(OP_ADD, SRC_P, SRC_X, SRC_ZERO, IM_NONE, FL_NONE);
      6'd18: u = mk(OP_ADD, SRC_P1, SRC_ONE, SRC_ZERO, IM_NONE, FL_REC_ENTRY);
      6'd19: u = mk(OP_ADD, SRC_P2, SRC_P1, SRC_ZERO, IM_NONE, FL_NONE);
      6'd20: u = mk(OP_ADD, SRC_P1, SRC_P, SRC_ZERO, IM_NONE, FL_NONE);
      6'd21: u = mk(OP_MULI, SRC_A, SRC_X, SRC_IMM, IM_2L1, FL_NONE);
      6'd22: u = mk(OP_MUL, SRC_A, SRC_A, SRC_P1, IM_NONE, FL_NONE);
      6'd23: u = mk(OP_MULI, SRC_B, SRC_P2, SRC_IMM, IM_LM1, FL_NONE);
      6'd24: u = mk(OP_SUB, SRC_A, SRC_A, SRC_B, IM_NONE, FL_NONE);
      6'd25: u = mk(OP_DIVI, SRC_P, SRC_A, SRC_IMM, IM_L, FL_REC_LOOP);
      // Newton step: derivative term and update.
      6'd26: u = mk(OP_SUB, SRC_A, SRC_ONE, SRC_X, IM_NONE, FL_NONE);
      6'd27: u = mk(OP_ADD, SRC_B, SRC_ONE, SRC_X, IM_NONE, FL_NONE);
      6'd28: u = mk(OP_MUL, SRC_A, SRC_A, SRC_B, IM_NONE, FL_NONE);
      6'd29: u = mk(OP_MUL, SRC_B, SRC_X, SRC_P, IM_NONE, FL_NONE);
      6'd30: u = mk(OP_SUB, SRC_B, SRC_P1, SRC_B, IM_NONE, FL_NONE);
      6'd31: u = mk(OP_MULI, SRC_B, SRC_B, SRC_IMM, IM_N, FL_NONE);
      6'd32: u = mk(OP_DIV, SRC_DP, SRC_A, SRC_B, IM_NONE, FL_NONE);
      6'd33: u = mk(OP_ADD, SRC_XO, SRC_X, SRC_ZERO, IM_NONE, FL_NONE);
      6'd34: u = mk(OP_MUL, SRC_A, SRC_P, SRC_DP, IM_NONE, FL_NONE);
      6'd35: u = mk(OP_SUB, SRC_X, SRC_X, SRC_A, IM_NONE, FL_NONE);
      6'd36: u = mk(OP_SUB, SRC_A, SRC_X, SRC_XO, IM_NONE, FL_NONE);
      6'd37: u = mk(OP_ADD, SRC_B, SRC_X, SRC_XO, IM_NONE, FL_NONE);
      6'd38: u = mk(OP_MUL, SRC_A, SRC_A, SRC_B, IM_NONE, FL_NEWTON_LOOP);
      // Weight.
      6'd39: u = mk(OP_MUL, SRC_A, SRC_DP, SRC_DP, IM_NONE, FL_NONE);
      6'd40: u = mk(OP_MULI, SRC_A, SRC_A, SRC_IMM, IM_TWO, FL_NONE);
      6'd41: u = mk(OP_SUB, SRC_B, SRC_ONE, SRC_X, IM_NONE, FL_NONE);
      6'd42: u = mk(OP_ADD, SRC_W, SRC_ONE, SRC_X, IM_NONE, FL_NONE);
      6'd43: u = mk(OP_MUL, SRC_B, SRC_B, SRC_W, IM_NONE, FL_NONE);
      6'd44: u = mk(OP_DIV, SRC_W, SRC_A, SRC_B, IM_NONE, FL_END);
      default: u = mk(OP_ADD, SRC_ZERO, SRC_ZERO, SRC_ZERO, IM_NONE, FL_END);
    endcase
    return u;
  endfunction

endpackage

// File: design/gauss_legendre_node_weight_unit.sv
// ----------------------------------------------------------------------------
// gauss_legendre_node_weight_unit
// Gauss-Legendre node and weight generator for a configured degree.
// ----------------------------------------------------------------------------
// Usage
//   degree must be written through the cfg_valid/cfg_ready channel (always
//   ready) while the unit is idle, which it does not enforce itself; values
//   above 64 act as 64, reset value is 16. A request transaction carries
//   node_index on in_valid/in_ready; the result transaction carries
//   node_value (Q1.30), node_weight (Q2.30) and index_error on
//   out_valid/out_ready. One request is processed at a time. An index at or
//   above the degree is answered with index_error set and without using the
//   datapath. Otherwise the shared datapath runs every operation in turn, for
//   at most 10 Newton steps, each with one step of the Legendre recurrence per
//   degree. The divider takes the largest share of the time.
//   The finished result sits in an output register; a stalled receiver
//   holds it there, a new request is still accepted and computed, and that
//   result waits until the register frees. Reset empties the output register
//   and returns the sequencer to idle.
// ----------------------------------------------------------------------------
module gauss_legendre_node_weight_unit (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       in_valid,
  output logic                       in_ready,
  input  logic [glnw_pkg::IDX_W-1:0] node_index,
  output logic                       out_valid,
  input  logic                       out_ready,
  output logic signed [31:0]         node_value,
  output logic [31:0]                node_weight,
  output logic                       index_error,
  input  logic                       cfg_valid,
  output logic                       cfg_ready,
  input  logic [glnw_pkg::DEG_W-1:0] degree
);
  import glnw_pkg::*;

  logic [DEG_W-1:0] degree_reg;
  logic             out_free, out_load, out_err;
  dp_cmd_t          cmd;
  dp_stat_t         stat;
  logic [31:0]      node_q30, weight_q30;

  // Configuration register.
  assign cfg_ready = 1'b1;
  always_ff @(posedge clk) begin
    if (rst) begin
      degree_reg <= DEG_W'(16);
    end else if (cfg_valid) begin
      degree_reg <= degree;
    end
  end

  glnw_controller u_ctrl (
    .clk        (clk),
    .rst        (rst),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .node_index (node_index),
    .degree     (degree_reg),
    .out_free   (out_free),
    .out_load   (out_load),
    .out_err    (out_err),
    .cmd        (cmd),
    .stat       (stat)
  );

  glnw_datapath u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .stat       (stat),
    .node_q30   (node_q30),
    .weight_q30 (weight_q30)
  );

  // Output register between the sequencer and the receiver.
  assign out_free = !out_valid || out_ready;
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      node_value  <= out_err ? 32'sd0 : $signed(node_q30);
      node_weight <= out_err ? 32'd0 : weight_q30;
      index_error <= out_err;
    end
  end

endmodule

// File: design/glnw_datapath.sv
// ----------------------------------------------------------------------------
// glnw_datapath
// Fixed-point register set with a shared saturating add/subtract, a
// multiplier working on 31-bit partial products and a two-bit-per-cycle
// restoring divider. Also converts the final node and weight to Q30.
// ----------------------------------------------------------------------------
module glnw_datapath (
  input  logic               clk,
  input  logic               rst,
  input  glnw_pkg::dp_cmd_t  cmd,
  output glnw_pkg::dp_stat_t stat,
  output logic [31:0]        node_q30,
  output logic [31:0]        weight_q30
);
  import glnw_pkg::*;

  localparam logic [1:0] DS_IDLE = 2'd0;
  localparam logic [1:0] DS_MUL  = 2'd1;
  localparam logic [1:0] DS_DIV  = 2'd2;
  localparam logic [1:0] DS_WB   = 2'd3;

  localparam int          Q_SHIFT = FRAC_BITS - 30;
  localparam logic [63:0] ROUND_Q = (Q_SHIFT > 0) ? (64'd1 << (Q_SHIFT - 1)) : 64'd0;
  localparam logic [ACC_W-1:0] LIM_ACC = ACC_W'(LIM);
  localparam logic [ACC_W-1:0] RND_MUL = ACC_W'(1) << (FRAC_BITS - 1);

  logic [1:0] st;
  logic [4:0] cnt;

  // Working registers.
  logic [63:0] x, xo, p, p1, p2, dp, c, term, t2, ra, rb, w;

  // Latched operation.
  logic [2:0]       op_q;
  logic [3:0]       dst_q;
  logic [63:0]      av, bv, ma, mb;
  logic [ACC_W-1:0] acc;
  logic [63:0]      r, dl, q;
  logic             divz, ovf;

  logic [63:0] opa, opb, opa_mag, opb_mag, div_hi;

  function automatic logic [63:0] pick(input logic [3:0] sel, input logic [IMM_W-1:0] imm);
    logic [63:0] v;
    case (sel)
      SRC_X:    v = x;
      SRC_XO:   v = xo;
      SRC_P:    v = p;
      SRC_P1:   v = p1;
      SRC_P2:   v = p2;
      SRC_DP:   v = dp;
      SRC_C:    v = c;
      SRC_TERM: v = term;
      SRC_T2:   v = t2;
      SRC_A:    v = ra;
      SRC_B:    v = rb;
      SRC_W:    v = w;
      SRC_ONE:  v = ONE_F;
      SRC_PI:   v = PI_F;
      SRC_IMM:  v = 64'(imm);
      default:  v = 64'd0;
    endcase
    return v;
  endfunction

  // One restoring division step: remainder in the upper bits, quotient bit last.
  function automatic logic [64:0] div_step(input logic [63:0] rem, input logic bin,
                                           input logic [63:0] d);
    logic [64:0] re;
    logic [64:0] diff;
    re   = {rem, bin};
    diff = re - {1'b0, d};
    if (re >= {1'b0, d}) return {diff[63:0], 1'b1};
    return {re[63:0], 1'b0};
  endfunction

  // Operand selection and set-up of the divider.
  always_comb begin
    opa     = pick(cmd.sa, cmd.imm);
    opb     = pick(cmd.sb, cmd.imm);
    opa_mag = opa[63] ? (64'd0 - opa) : opa;
    opb_mag = opb[63] ? (64'd0 - opb) : opb;
    div_hi  = (cmd.op == OP_DIV) ? (opa_mag >> (64 - FRAC_BITS)) : 64'd0;
  end

  // Partial product for the current quarter of the multiplication.
  logic [HALF_W-1:0]   a_half, b_half;
  logic [2*HALF_W-1:0] pp;
  logic [ACC_W-1:0]    pp_sh;

  always_comb begin
    a_half = cnt[1] ? ma[2*HALF_W-1:HALF_W] : ma[HALF_W-1:0];
    b_half = cnt[0] ? mb[2*HALF_W-1:HALF_W] : mb[HALF_W-1:0];
    pp     = (2*HALF_W)'(a_half) * (2*HALF_W)'(b_half);
    case (cnt[1:0])
      2'd0:    pp_sh = ACC_W'(pp);
      2'd3:    pp_sh = ACC_W'(pp) << (2 * HALF_W);
      default: pp_sh = ACC_W'(pp) << HALF_W;
    endcase
  end

  // Two division steps per cycle.
  logic [64:0] s1, s2;
  always_comb begin
    s1 = div_step(r, dl[63], mb);
    s2 = div_step(s1[64:1], dl[62], mb);
  end

  // Result of the finished operation, saturated to the limit.
  logic [64:0]      sum, sum_mag;
  logic [ACC_W-1:0] rnd;
  logic [ACC_W-1:0] sh;
  logic [63:0]      res_mag, res;
  logic             res_neg;

  always_comb begin
    sum     = (op_q == OP_SUB) ? ({av[63], av} - {bv[63], bv}) : ({av[63], av} + {bv[63], bv});
    sum_mag = sum[64] ? (65'd0 - sum) : sum;
    rnd     = acc + RND_MUL;
    sh      = rnd >> FRAC_BITS;
    res_neg = av[63] ^ bv[63];
    res_mag = 64'd0;
    case (op_q)
      OP_ADD, OP_SUB: begin
        res_neg = sum[64];
        res_mag = (sum_mag > 65'(LIM)) ? LIM : sum_mag[63:0];
      end
      OP_MUL: begin
        res_mag = (sh > LIM_ACC) ? LIM : sh[63:0];
      end
      OP_MULI: begin
        res_mag = (acc > LIM_ACC) ? LIM : acc[63:0];
      end
      default: begin
        if (divz) begin
          res_neg = av[63];
          res_mag = (ma == 64'd0) ? 64'd0 : LIM;
        end else if (ovf) begin
          res_mag = LIM;
        end else begin
          res_mag = (q > LIM) ? LIM : q;
        end
      end
    endcase
    res = res_neg ? (64'd0 - res_mag) : res_mag;
  end

  assign stat.done      = (st == DS_WB);
  assign stat.below_tol = (res_mag < TOL);

  // Operation sequencing and register write-back.
  always_ff @(posedge clk) begin
    if (rst) begin
      st  <= DS_IDLE;
      cnt <= '0;
    end else begin
      unique case (st)
        DS_IDLE: begin
          if (cmd.start) begin
            op_q  <= cmd.op;
            dst_q <= cmd.dst;
            av    <= opa;
            bv    <= opb;
            ma    <= opa_mag;
            mb    <= opb_mag;
            acc   <= '0;
            q     <= '0;
            cnt   <= '0;
            r     <= div_hi;
            dl    <= (cmd.op == OP_DIV) ? (opa_mag << FRAC_BITS) : opa_mag;
            divz  <= (opb_mag == 64'd0);
            ovf   <= (div_hi >= opb_mag);
            case (cmd.op)
              OP_ADD, OP_SUB:  st <= DS_WB;
              OP_MUL, OP_MULI: st <= DS_MUL;
              default: begin
                st <= ((opb_mag == 64'd0) || (div_hi >= opb_mag)) ? DS_WB : DS_DIV;
              end
            endcase
          end
        end
        DS_MUL: begin
          acc <= acc + pp_sh;
          cnt <= cnt + 5'd1;
          if (cnt[1:0] == 2'd3) st <= DS_WB;
        end
        DS_DIV: begin
          r   <= s2[64:1];
          dl  <= dl << 2;
          q   <= {q[61:0], s1[0], s2[0]};
          cnt <= cnt + 5'd1;
          if (cnt == 5'(DIV_CYCLES - 1)) st <= DS_WB;
        end
        DS_WB: begin
          case (dst_q)
            SRC_X:    x    <= res;
            SRC_XO:   xo   <= res;
            SRC_P:    p    <= res;
            SRC_P1:   p1   <= res;
            SRC_P2:   p2   <= res;
            SRC_DP:   dp   <= res;
            SRC_C:    c    <= res;
            SRC_TERM: term <= res;
            SRC_T2:   t2   <= res;
            SRC_A:    ra   <= res;
            SRC_B:    rb   <= res;
            SRC_W:    w    <= res;
            default: ;
          endcase
          st <= DS_IDLE;
        end
        default: st <= DS_IDLE;
      endcase
    end
  end

  // Conversion of the converged node and the weight to Q30 output formats.
  logic [63:0] vx, nmag, nr, wr;
  always_comb begin
    vx   = cmd.mirror ? (64'd0 - x) : x;
    nmag = vx[63] ? (64'd0 - vx) : vx;
    nr   = (nmag + ROUND_Q) >> Q_SHIFT;
    if (nr > (64'd1 << 30)) nr = 64'd1 << 30;
    node_q30 = vx[63] ? (32'd0 - nr[31:0]) : nr[31:0];
    wr = (w + ROUND_Q) >> Q_SHIFT;
    if (w[63]) begin
      weight_q30 = 32'd0;
    end else begin
      weight_q30 = (wr > (64'd1 << 31)) ? 32'h8000_0000 : wr[31:0];
    end
  end

endmodule

// File: design/glnw_controller.sv
// ----------------------------------------------------------------------------
// glnw_controller
// Micro-sequencer that walks the micro-program, issues one operation at a
// time to the datapath and keeps the loop counters of the cosine series,
// the Legendre recurrence and the Newton iteration.
// ----------------------------------------------------------------------------
module glnw_controller (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [glnw_pkg::IDX_W-1:0]     node_index,
  input  logic [glnw_pkg::DEG_W-1:0]     degree,
  input  logic                           out_free,
  output logic                           out_load,
  output logic                           out_err,
  output glnw_pkg::dp_cmd_t              cmd,
  input  glnw_pkg::dp_stat_t             stat
);
  import glnw_pkg::*;

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_ISSUE = 2'd1;
  localparam logic [1:0] ST_WAIT  = 2'd2;
  localparam logic [1:0] ST_OUT   = 2'd3;

  logic [1:0]      state;
  logic [N_W-1:0]  n, i;
  logic            mirror, err;
  logic [PC_W-1:0] pc;
  logic [L_W-1:0]  l;
  logic [J_W-1:0]  j;

  uop_t             u;
  logic [IMM_W-1:0] imm;

  // Decode of a new request.
  logic [N_W-1:0] n_eff, k;
  logic           k_err, k_mirror;
  always_comb begin
    n_eff    = (degree > DEG_W'(MAX_DEGREE)) ? N_W'(MAX_DEGREE) : N_W'(degree);
    k        = N_W'(node_index);
    k_err    = (k >= n_eff);
    k_mirror = (k >= (n_eff >> 1));
  end

  // Immediate operand for the current micro-operation.
  always_comb begin
    u = uop_at(pc);
    case (u.imm)
      IM_4I1:   imm = IMM_W'({i, 2'b00}) - IMM_W'(1);
      IM_4N2:   imm = IMM_W'({n, 2'b00}) + IMM_W'(2);
      IM_N:     imm = IMM_W'(n);
      IM_NM1:   imm = IMM_W'(n) - IMM_W'(1);
      IM_COSK:  imm = cos_div(l[3:0]);
      IM_2L1:   imm = IMM_W'({l, 1'b0}) - IMM_W'(1);
      IM_LM1:   imm = IMM_W'(l) - IMM_W'(1);
      IM_L:     imm = IMM_W'(l);
      IM_TWO:   imm = IMM_W'(2);
      IM_EIGHT: imm = IMM_W'(8);
      default:  imm = '0;
    endcase
  end

  assign cmd.start  = (state == ST_ISSUE);
  assign cmd.op     = u.op;
  assign cmd.dst    = u.dst;
  assign cmd.sa     = u.sa;
  assign cmd.sb     = u.sb;
  assign cmd.imm    = imm;
  assign cmd.mirror = mirror;

  assign in_ready = (state == ST_IDLE);
  assign out_load = (state == ST_OUT) && out_free;
  assign out_err  = err;

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      pc    <= '0;
    end else begin
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            n      <= n_eff;
            err    <= k_err;
            mirror <= k_mirror;
            i      <= k_mirror ? (n_eff - k) : (k + N_W'(1));
            pc     <= '0;
            state  <= k_err ? ST_OUT : ST_ISSUE;
          end
        end
        ST_ISSUE: state <= ST_WAIT;
        ST_WAIT: begin
          if (stat.done) begin
            state <= ST_ISSUE;
            pc    <= pc + PC_W'(1);
            case (u.flow)
              FL_COS_INIT: l <= L_W'(1);
              FL_COS_LOOP: begin
                if (l < L_W'(COS_TERMS)) begin
                  l  <= l + L_W'(1);
                  pc <= PC_COS_BODY;
                end
              end
              FL_NEWTON_INIT: j <= '0;
              FL_REC_ENTRY: begin
                l <= L_W'(2);
                if (n < N_W'(2)) pc <= PC_REC_END;
              end
              FL_REC_LOOP: begin
                if (l < L_W'(n)) begin
                  l  <= l + L_W'(1);
                  pc <= PC_REC_BODY;
                end
              end
              FL_NEWTON_LOOP: begin
                if (!stat.below_tol && (j != J_W'(MAX_NEWTON_STEPS - 1))) begin
                  j  <= j + J_W'(1);
                  pc <= PC_NEWTON_TOP;
                end
              end
              FL_END: state <= ST_OUT;
              default: ;
            endcase
          end
        end
        ST_OUT: begin
          if (out_free) state <= ST_IDLE;
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// File: design/glnw_checker.sv
// ----------------------------------------------------------------------------
// glnw_checker
// Port-level checks of the node and weight unit, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module glnw_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       in_valid,
  input logic                       in_ready,
  input logic [glnw_pkg::IDX_W-1:0] node_index,
  input logic                       out_valid,
  input logic                       out_ready,
  input logic signed [31:0]         node_value,
  input logic [31:0]                node_weight,
  input logic                       index_error,
  input logic                       cfg_valid,
  input logic                       cfg_ready,
  input logic [glnw_pkg::DEG_W-1:0] degree
);

  // An index error result carries a zero node and weight.
  `GLNW_ASSERT_IMP(a_err_zero, out_valid && index_error, node_value == 32'sd0 && node_weight == 32'd0, "index error with nonzero payload")

  // Node stays within [-1, 1] and the weight within [0, 2].
  `GLNW_ASSERT_IMP(a_node_range, out_valid, node_value <= 32'sh4000_0000 && node_value >= -32'sh4000_0000, "node out of range")
  `GLNW_ASSERT_IMP(a_weight_range, out_valid, node_weight <= 32'h8000_0000, "weight out of range")

  // Only one request is in work at a time.
  `GLNW_ASSERT_NXT(a_one_at_a_time, in_valid && in_ready, !in_ready, "second request accepted while busy")

  // A stalled result holds.
  `GLNW_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(node_value) && $stable(node_weight), "stalled result changed")

endmodule

bind gauss_legendre_node_weight_unit glnw_checker u_glnw_checker (.*);
